// File: hdl/flia_pkg.sv
// shared types and constants of the free list index allocator
`default_nettype none

package flia_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CNT_W  = 11;

  localparam logic [CNT_W-1:0] POOL_SIZE_RST = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REFILL = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_POP   = 2'd2
  } state_e;

  typedef struct packed {
    logic    pop;
    logic    push;
    logic    refill;
    logic    sweep_step;
    logic    load_imm;
    logic    load_pop;
    status_e res_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic eff_zero;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/flia_ctrl.sv
// controller state machine of the free list index allocator
`default_nettype none

module flia_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic [flia_pkg::OP_W-1:0]    op_i,
  input  wire flia_pkg::dp_status_t         sts_i,
  output logic                              in_ready_o,
  output flia_pkg::ctl_cmd_t                cmd_o
);

  flia_pkg::state_e state_q, state_d;
  logic             accept;

  assign in_ready_o = (state_q == flia_pkg::S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flia_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      flia_pkg::S_CLEAR: begin
        if (sts_i.sweep_last) state_d = flia_pkg::S_IDLE;
      end
      flia_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            flia_pkg::OP_ALLOC: begin
              if (!sts_i.empty) state_d = flia_pkg::S_POP;
            end
            flia_pkg::OP_REFILL: begin
              if (!sts_i.eff_zero) state_d = flia_pkg::S_CLEAR;
            end
            default: state_d = flia_pkg::S_IDLE;
          endcase
        end
      end
      flia_pkg::S_POP: state_d = flia_pkg::S_IDLE;
      default: state_d = flia_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = flia_pkg::ST_OK;
    unique case (state_q)
      flia_pkg::S_CLEAR: cmd_o.sweep_step = 1'b1;
      flia_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            flia_pkg::OP_ALLOC: begin
              if (sts_i.empty) begin
                cmd_o.load_imm   = 1'b1;
                cmd_o.res_status = flia_pkg::ST_EXHAUSTED;
              end else begin
                cmd_o.pop = 1'b1;
              end
            end
            flia_pkg::OP_FREE: begin
              cmd_o.load_imm = 1'b1;
              if (sts_i.full) begin
                cmd_o.res_status = flia_pkg::ST_OVERFLOW;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            flia_pkg::OP_REFILL: begin
              cmd_o.refill   = 1'b1;
              cmd_o.load_imm = 1'b1;
            end
            default: cmd_o.load_imm = 1'b1;
          endcase
        end
      end
      flia_pkg::S_POP: cmd_o.load_pop = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/flia_dpath.sv
// datapath of the free list index allocator: stack memory, pointers, count, result register
`default_nettype none

module flia_dpath #(
  parameter int unsigned POOL_DEPTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire flia_pkg::ctl_cmd_t            cmd_i,
  input  wire logic [flia_pkg::IDX_W-1:0]    free_index_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [flia_pkg::CNT_W-1:0]    cfg_data_i,
  input  wire logic                          out_ready_i,
  output flia_pkg::dp_status_t               sts_o,
  output logic                               out_valid_o,
  output logic [flia_pkg::STAT_W-1:0]        status_o,
  output logic [flia_pkg::IDX_W-1:0]         slot_index_o,
  output logic [flia_pkg::CNT_W-1:0]         in_use_count_o
);

  localparam int unsigned TOP_W  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(POOL_DEPTH);
  localparam int unsigned CMP_W  = (TOP_W > flia_pkg::CNT_W) ? TOP_W : flia_pkg::CNT_W;
  localparam int unsigned RST_N  = (POOL_DEPTH < 1024) ? POOL_DEPTH : 1024;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(POOL_DEPTH);

  logic [flia_pkg::IDX_W-1:0] mem_q [POOL_DEPTH];

  logic [flia_pkg::CNT_W-1:0] pool_size_q;
  logic [TOP_W-1:0]           top_q, top_d;
  logic [TOP_W-1:0]           fill_n_q;
  logic [TOP_W-1:0]           sweep_cnt_q;
  logic [flia_pkg::CNT_W-1:0] count_q, count_d;
  logic [flia_pkg::IDX_W-1:0] rd_q;

  logic                       out_valid_q;
  flia_pkg::status_e          status_q;
  logic [flia_pkg::IDX_W-1:0] slot_q;
  logic [flia_pkg::CNT_W-1:0] out_cnt_q;

  logic [CMP_W-1:0]           pool_ext;
  logic [TOP_W-1:0]           eff_top;
  logic [TOP_W-1:0]           rd_addr;
  logic                       mem_we;
  logic [ADDR_W-1:0]          wr_addr;
  logic [flia_pkg::IDX_W-1:0] wr_data;

  // size clamped to the built depth
  assign pool_ext = CMP_W'(pool_size_q);
  assign eff_top  = TOP_W'((pool_ext > DEPTH_C) ? DEPTH_C : pool_ext);

  assign sts_o.empty      = (top_q == '0);
  assign sts_o.full       = (top_q >= eff_top);
  assign sts_o.eff_zero   = (eff_top == '0);
  assign sts_o.sweep_last = (sweep_cnt_q == fill_n_q - TOP_W'(1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign rd_addr = top_q - TOP_W'(1);

  always_comb begin
    top_d   = top_q;
    count_d = count_q;
    if (cmd_i.refill) begin
      top_d   = eff_top;
      count_d = '0;
    end else if (cmd_i.pop) begin
      top_d   = top_q - TOP_W'(1);
      count_d = count_q + flia_pkg::CNT_W'(1);
    end else if (cmd_i.push) begin
      top_d = top_q + TOP_W'(1);
      if (count_q != '0) count_d = count_q - flia_pkg::CNT_W'(1);
    end
  end

  // refill writes entry i with n-1-i
  always_comb begin
    mem_we  = cmd_i.push || cmd_i.sweep_step;
    wr_addr = cmd_i.push ? top_q[ADDR_W-1:0] : sweep_cnt_q[ADDR_W-1:0];
    wr_data = cmd_i.push ? free_index_i
                         : flia_pkg::IDX_W'(fill_n_q - TOP_W'(1) - sweep_cnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) rd_q <= mem_q[rd_addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= flia_pkg::POOL_SIZE_RST;
      top_q       <= TOP_W'(RST_N);
      fill_n_q    <= TOP_W'(RST_N);
      sweep_cnt_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) pool_size_q <= cfg_data_i;
      top_q   <= top_d;
      count_q <= count_d;
      if (cmd_i.refill) begin
        fill_n_q    <= eff_top;
        sweep_cnt_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sweep_cnt_q <= sweep_cnt_q + TOP_W'(1);
      end
      if (cmd_i.load_imm || cmd_i.load_pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_imm) begin
      status_q  <= cmd_i.res_status;
      slot_q    <= '0;
      out_cnt_q <= count_d;
    end else if (cmd_i.load_pop) begin
      status_q  <= flia_pkg::ST_OK;
      slot_q    <= rd_q;
      out_cnt_q <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_index_o   = slot_q;
  assign in_use_count_o = out_cnt_q;

endmodule

`default_nettype wire

// File: hdl/free_list_index_allocator.sv
// free list index allocator: free, refill and exhausted alloc load the result register
// straight from the request, a granting alloc via the registered stack memory read
// and the pop read state; no new item is taken in that state or while a result waits
// after reset and after each refill to a nonzero size the stack is reloaded
// one entry a cycle, and no item is accepted meanwhile
// configuration writes are taken at any time
`default_nettype none

module free_list_index_allocator #(
  parameter int unsigned POOL_DEPTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [flia_pkg::CNT_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [flia_pkg::OP_W-1:0]     op_i,
  input  wire logic [flia_pkg::IDX_W-1:0]    free_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [flia_pkg::STAT_W-1:0]        status_o,
  output logic [flia_pkg::IDX_W-1:0]         slot_index_o,
  output logic [flia_pkg::CNT_W-1:0]         in_use_count_o
);

  flia_pkg::ctl_cmd_t   cmd;
  flia_pkg::dp_status_t sts;

  assign cfg_ready_o = 1'b1;

  flia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  flia_dpath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .free_index_i   (free_index_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (out_ready_i),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .in_use_count_o (in_use_count_o)
  );

endmodule

`default_nettype wire

// File: test/free_list_index_allocator_test.sv
// self-checking testbench for the free list index allocator: directed and random items
module free_list_index_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_DEPTH = 1024;
  localparam int LIMIT_CYCLES = 2000000;
  localparam logic [flia_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [flia_pkg::STAT_W-1:0] status;
    logic [flia_pkg::IDX_W-1:0]  slot;
    logic [flia_pkg::CNT_W-1:0]  count;
  } alloc_reply_t;

  class alloc_ledger;
    logic [flia_pkg::IDX_W-1:0] free_stack [POOL_DEPTH];
    logic [flia_pkg::CNT_W-1:0] stack_top;
    logic [flia_pkg::CNT_W-1:0] allocated;
    logic [flia_pkg::CNT_W-1:0] pool_size;
    alloc_reply_t               replies [$];
    logic [flia_pkg::IDX_W-1:0] granted [$];
    int                         errors;

    function new();
      pool_size = flia_pkg::POOL_SIZE_RST;
      errors = 0;
      refill();
    endfunction

    function logic [flia_pkg::CNT_W-1:0] active_size();
      return (pool_size > POOL_DEPTH) ? flia_pkg::CNT_W'(POOL_DEPTH) : pool_size;
    endfunction

    function void refill();
      logic [flia_pkg::CNT_W-1:0] n;
      n = active_size();
      for (int i = 0; i < POOL_DEPTH; i++) begin
        free_stack[i] = (i < n) ? flia_pkg::IDX_W'(n - 1 - i) : '0;
      end
      stack_top = n;
      allocated = '0;
      granted.delete();
    endfunction

    function void post_request(logic [flia_pkg::OP_W-1:0] op,
                               logic [flia_pkg::IDX_W-1:0] idx);
      alloc_reply_t r;
      r.status = flia_pkg::ST_OK;
      r.slot = '0;
      case (op)
        flia_pkg::OP_ALLOC: begin
          if (stack_top == 0 || stack_top > POOL_DEPTH) begin
            r.status = flia_pkg::ST_EXHAUSTED;
          end else begin
            stack_top = stack_top - 1'b1;
            r.slot = free_stack[stack_top[flia_pkg::IDX_W-1:0]];
            allocated = allocated + 1'b1;
            granted.push_back(r.slot);
          end
        end
        flia_pkg::OP_FREE: begin
          if (stack_top >= active_size()) begin
            r.status = flia_pkg::ST_OVERFLOW;
          end else begin
            free_stack[stack_top[flia_pkg::IDX_W-1:0]] = idx;
            stack_top = stack_top + 1'b1;
            if (allocated > 0) allocated = allocated - 1'b1;
          end
        end
        flia_pkg::OP_REFILL: refill();
        default: ;
      endcase
      r.count = allocated;
      replies.push_back(r);
    endfunction

    function void match_reply(logic [flia_pkg::STAT_W-1:0] status,
                              logic [flia_pkg::IDX_W-1:0] slot,
                              logic [flia_pkg::CNT_W-1:0] count);
      alloc_reply_t want;
      alloc_reply_t got;
      got = '{status, slot, count};
      if (replies.size() == 0) begin
        $display("%0t: unexpected result: status %0d slot %0d count %0d",
                 $time, status, slot, count);
        errors++;
        return;
      end
      want = replies.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch: expected status %0d slot %0d count %0d, ",
                 $time, want.status, want.slot, want.count,
                 "actual status %0d slot %0d count %0d",
                 got.status, got.slot, got.count);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [flia_pkg::CNT_W-1:0]   cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [flia_pkg::OP_W-1:0]    op_i = '0;
  logic [flia_pkg::IDX_W-1:0]   free_index_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [flia_pkg::STAT_W-1:0]  status_o;
  logic [flia_pkg::IDX_W-1:0]   slot_index_o;
  logic [flia_pkg::CNT_W-1:0]   in_use_count_o;

  alloc_ledger ledger;
  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;

  free_list_index_allocator #(.POOL_DEPTH(POOL_DEPTH)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .free_index_i   (free_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .in_use_count_o (in_use_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // items are noted before results are matched so a same-edge pair stays in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) ledger.post_request(op_i, free_index_i);
      if (out_valid_o && out_ready_i) ledger.match_reply(status_o, slot_index_o, in_use_count_o);
    end
  end

  task automatic send_item(logic [flia_pkg::OP_W-1:0] op, logic [flia_pkg::IDX_W-1:0] idx,
                           bit reuse_held);
    int j;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    // mostly return a slot that is really out
    if (reuse_held && ledger.granted.size() != 0 && $urandom_range(99) < 80) begin
      j = $urandom_range(ledger.granted.size() - 1);
      idx = ledger.granted[j];
      ledger.granted.delete(j);
    end
    in_valid_i = 1'b1;
    op_i = op;
    free_index_i = idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_pool_size(logic [flia_pkg::CNT_W-1:0] size);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (ledger.replies.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    // let a refill sweep finish before the size changes
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = size;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ledger.pool_size = size;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, logic [flia_pkg::CNT_W-1:0] size,
                           int n, int alloc_pct);
    int pick;
    logic [flia_pkg::OP_W-1:0] op;
    send_idle = idle_pct;
    recv_stall = stall_pct;
    write_pool_size(size);
    send_item(flia_pkg::OP_REFILL, flia_pkg::IDX_W'($urandom), 1'b0);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < alloc_pct) op = flia_pkg::OP_ALLOC;
      else if (pick < 95) op = flia_pkg::OP_FREE;
      else if (pick < 98) op = flia_pkg::OP_REFILL;
      else op = OP_UNUSED;
      send_item(op, flia_pkg::IDX_W'($urandom), op == flia_pkg::OP_FREE);
    end
  endtask

  initial begin
    ledger = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // full pool after reset
    send_item(flia_pkg::OP_FREE, 10'h3ff, 1'b0);
    send_item(flia_pkg::OP_ALLOC, '0, 1'b0);
    send_item(flia_pkg::OP_ALLOC, '0, 1'b0);
    send_item(flia_pkg::OP_FREE, 10'h3ff, 1'b0);
    send_item(flia_pkg::OP_ALLOC, '0, 1'b0);
    send_item(flia_pkg::OP_FREE, 10'h000, 1'b0);
    send_item(OP_UNUSED, 10'h2aa, 1'b0);
    send_item(flia_pkg::OP_ALLOC, '0, 1'b0);
    send_item(flia_pkg::OP_REFILL, '0, 1'b0);

    // size shrunk without refill, then one slot
    write_pool_size(11'd1);
    send_item(flia_pkg::OP_ALLOC, '0, 1'b0);
    send_item(flia_pkg::OP_FREE, 10'h155, 1'b0);
    send_item(flia_pkg::OP_REFILL, '0, 1'b0);
    send_item(flia_pkg::OP_ALLOC, '0, 1'b0);
    send_item(flia_pkg::OP_ALLOC, '0, 1'b0);
    send_item(flia_pkg::OP_FREE, 10'h2aa, 1'b0);
    send_item(flia_pkg::OP_FREE, 10'h000, 1'b0);
    send_item(flia_pkg::OP_ALLOC, '0, 1'b0);

    // empty pool
    write_pool_size(11'd0);
    send_item(flia_pkg::OP_FREE, 10'h005, 1'b0);
    send_item(flia_pkg::OP_REFILL, '0, 1'b0);
    send_item(flia_pkg::OP_ALLOC, '0, 1'b0);
    send_item(flia_pkg::OP_FREE, 10'h001, 1'b0);

    // oversized pool acts as the full depth
    write_pool_size(11'd2047);
    send_item(flia_pkg::OP_REFILL, '0, 1'b0);
    send_item(flia_pkg::OP_ALLOC, '0, 1'b0);
    send_item(flia_pkg::OP_FREE, 10'h3ff, 1'b0);

    run_phase(0, 0, 11'd6, 120, 48);
    run_phase(80, 0, 11'd1025, 100, 45);
    run_phase(0, 80, 11'd17, 120, 48);
    run_phase(27, 27, 11'd1, 80, 48);
    run_phase(0, 0, 11'd1024, 140, 65);
    run_phase(27, 27, flia_pkg::CNT_W'($urandom_range(64, 2)), 100, 50);
    run_phase(0, 80, 11'd0, 20, 50);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (ledger.replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
